FILE: rtl/altkey_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altkey_pkg
// shared types and constants for the alt keypad code entry block
// ----------------------------------------------------------------------------
package altkey_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_HOLD_MODIFIER = 2'd0;
    localparam logic [1:0] CFG_KEYPAD_ZERO   = 2'd1;
    localparam logic [1:0] CFG_KEYPAD_ONE    = 2'd2;

    // register reset values
    localparam logic [7:0] HOLD_MODIFIER_RST = 8'h40;
    localparam logic [7:0] KEYPAD_ZERO_RST   = 8'd98;
    localparam logic [7:0] KEYPAD_ONE_RST    = 8'd89;

    localparam logic [7:0] ESCAPE_BYTE = 8'hFF;

    // five decimal digits, press and release each, then the final pair
    localparam int         NUM_DIGITS = 5;
    localparam logic [3:0] LAST_STEP  = 4'd10;

    // byte parser phases
    typedef enum logic [2:0] {
        PH_CODE = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } phase_t;

    // multiples of each decimal weight, most significant digit first
    localparam logic [16:0] DIGIT_STEP [NUM_DIGITS][10] = '{
        '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
          17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
        '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
          17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
        '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
          17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
        '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
          17'd50, 17'd60, 17'd70, 17'd80, 17'd90},
        '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4,
          17'd5, 17'd6, 17'd7, 17'd8, 17'd9}
    };

endpackage

FILE: rtl/char_code_to_alt_keypad_keys.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_code_to_alt_keypad_keys
// turns a byte stream of character codes into keypad report pairs that type
// each code as five decimal digits while a modifier is held
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  in_byte
//  output    out        out_valid/out_stall  modifier, key_usage, last_of_run
//  config    in         cfg_we               cfg_index, cfg_data
//
//  every input transaction is taken by the parser; a finished code
//  is held in a one-entry code register and played out by the emit
//  sequencer as eleven report pairs, one pair per cycle when not stalled
//  the sequencer loads the next pending code on the cycle it sends the
//  final pair, so consecutive codes stream with no gap
//  escape and high bytes give no output
//  rst_n clears parser, pending code flag, sequencer and output valid and
//  loads the register defaults
//  a stalled output holds its pair and freezes the sequencer; in_stall is
//  high while a finished code waits for the sequencer
//
module char_code_to_alt_keypad_keys
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] modifier,
    output logic [7:0] key_usage,
    output logic       last_of_run,

    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    // configuration registers
    logic [7:0] hold_mod_reg;
    logic [7:0] zero_usage_reg;
    logic [7:0] one_usage_reg;

    // parser and pending code register
    altkey_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  high_reg, high_next;
    logic        code_valid_reg, code_valid_next;
    logic [15:0] code_reg, code_next;

    // emit sequencer
    logic        busy_reg, busy_next;
    logic [3:0]  step_reg, step_next;
    logic [15:0] rem_reg, rem_next;
    logic [3:0]  digit_reg, digit_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  modifier_reg, modifier_next;
    logic [7:0]  key_usage_reg, key_usage_next;
    logic        last_reg, last_next;

    logic        in_fire;
    logic        advance;
    logic        finish;
    logic        load;
    logic [2:0]  digit_pos;
    logic [3:0]  digit_now;
    logic [7:0]  usage_now;

    assign in_stall = code_valid_reg;
    assign in_fire  = in_valid && !code_valid_reg;

    // output register is free or being emptied this cycle
    assign advance = !out_valid_reg || !out_stall;
    assign finish  = busy_reg && advance && (step_reg == altkey_pkg::LAST_STEP);
    // pick up the next code when idle, or straight after the final pair
    assign load    = code_valid_reg && (!busy_reg || finish);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_mod_reg   <= altkey_pkg::HOLD_MODIFIER_RST;
            zero_usage_reg <= altkey_pkg::KEYPAD_ZERO_RST;
            one_usage_reg  <= altkey_pkg::KEYPAD_ONE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                altkey_pkg::CFG_HOLD_MODIFIER: hold_mod_reg   <= cfg_data;
                altkey_pkg::CFG_KEYPAD_ZERO:   zero_usage_reg <= cfg_data;
                altkey_pkg::CFG_KEYPAD_ONE:    one_usage_reg  <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // byte parser: plain code, or escape followed by high then low byte
    always_comb
    begin
        phase_next      = phase_reg;
        high_next       = high_reg;
        code_valid_next = code_valid_reg;
        code_next       = code_reg;
        if (load)
        begin
            code_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            case (phase_reg)
                altkey_pkg::PH_HIGH:
                begin
                    high_next  = in_byte;
                    phase_next = altkey_pkg::PH_LOW;
                end
                altkey_pkg::PH_LOW:
                begin
                    code_next       = {high_reg, in_byte};
                    code_valid_next = 1'b1;
                    phase_next      = altkey_pkg::PH_CODE;
                end
                default:
                begin
                    if (in_byte == altkey_pkg::ESCAPE_BYTE)
                    begin
                        phase_next = altkey_pkg::PH_HIGH;
                    end
                    else
                    begin
                        code_next       = {8'h00, in_byte};
                        code_valid_next = 1'b1;
                        phase_next      = altkey_pkg::PH_CODE;
                    end
                end
            endcase
        end
    end

    // current decimal digit: how many multiples of its weight fit in the
    // remainder, weights run from ten thousands down to units
    assign digit_pos = (step_reg[3:1] < 3'(altkey_pkg::NUM_DIGITS)) ? step_reg[3:1] : 3'd0;

    always_comb
    begin
        digit_now = 4'd0;
        for (int j = 1; j < 10; j++)
        begin
            if ({1'b0, rem_reg} >= altkey_pkg::DIGIT_STEP[digit_pos][j])
            begin
                digit_now = 4'(j);
            end
        end
    end

    // zero has its own usage, one to nine are contiguous (wraps modulo 256)
    assign usage_now = (digit_now == 4'd0) ? zero_usage_reg
                     : 8'(one_usage_reg + {4'h0, digit_now} - 8'd1);

    // emit sequencer and output register
    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        digit_next     = digit_reg;
        out_valid_next = out_valid_reg;
        modifier_next  = modifier_reg;
        key_usage_next = key_usage_reg;
        last_next      = last_reg;

        if (advance)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == altkey_pkg::LAST_STEP)
                begin
                    // final all-released pair
                    busy_next      = 1'b0;
                    modifier_next  = 8'h00;
                    key_usage_next = 8'h00;
                    last_next      = 1'b1;
                end
                else if (!step_reg[0])
                begin
                    // press pair
                    digit_next     = digit_now;
                    modifier_next  = hold_mod_reg;
                    key_usage_next = usage_now;
                    last_next      = 1'b0;
                end
                else
                begin
                    // release pair, strip the digit just typed
                    rem_next       = 16'(({1'b0, rem_reg}
                                     - altkey_pkg::DIGIT_STEP[digit_pos][digit_reg]));
                    modifier_next  = hold_mod_reg;
                    key_usage_next = 8'h00;
                    last_next      = 1'b0;
                end
            end
        end

        if (load)
        begin
            busy_next = 1'b1;
            step_next = 4'd0;
            rem_next  = code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= altkey_pkg::PH_CODE;
            high_reg       <= 8'h00;
            code_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            step_reg       <= 4'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            high_reg       <= high_next;
            code_valid_reg <= code_valid_next;
            busy_reg       <= busy_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        rem_reg       <= rem_next;
        digit_reg     <= digit_next;
        modifier_reg  <= modifier_next;
        key_usage_reg <= key_usage_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign modifier    = modifier_reg;
    assign key_usage   = key_usage_reg;
    assign last_of_run = last_reg;

endmodule

FILE: rtl/altkey_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altkey_checker
// port level checks on the alt keypad code entry block
// ----------------------------------------------------------------------------
module altkey_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] modifier,
    input logic [7:0] key_usage,
    input logic       last_of_run,
    input logic       cfg_we
);

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte))
        else $error("input changed while stalled");

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(modifier)
            && $stable(key_usage) && $stable(last_of_run))
        else $error("output changed while stalled");

    // final pair is all released
    a_last_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_run |-> modifier == 8'h00 && key_usage == 8'h00)
        else $error("final pair not released");

    // a key press is followed at once by its release
    a_press_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && key_usage != 8'h00
            |=> out_valid && key_usage == 8'h00 && !last_of_run)
        else $error("press without following release");

    // register writes only while the block is quiet
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !in_valid && !out_valid)
        else $error("register write with traffic in flight");

endmodule

bind char_code_to_alt_keypad_keys altkey_checker u_altkey_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .modifier    (modifier),
    .key_usage   (key_usage),
    .last_of_run (last_of_run),
    .cfg_we      (cfg_we)
);

FILE: dv/altkey_keystroke_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altkey_keystroke_checker
// watches the byte, report and register ports, predicts the key report pairs
// and compares every report transaction against the oldest predicted pair
// ----------------------------------------------------------------------------
module altkey_keystroke_checker
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,

    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] modifier,
    input  logic [7:0] key_usage,
    input  logic       last_of_run,

    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,

    output int         mismatches,
    output int         reports_due
);

    typedef struct packed {
        logic [7:0] modifier;
        logic [7:0] key_usage;
        logic       last_of_run;
    } key_report_t;

    key_report_t expected_reports [$];

    // predictor state and register copies
    altkey_pkg::phase_t byte_phase;
    logic [7:0] held_high;
    logic [7:0] held_modifier_cfg;
    logic [7:0] zero_usage_cfg;
    logic [7:0] one_usage_cfg;
    int         fail_tally;

    // five digits, press and release each, then the all-released pair
    function automatic void queue_code_reports(input logic [15:0] code);
        logic [3:0] digit [altkey_pkg::NUM_DIGITS];
        logic [7:0] usage;
        int         rest;
        rest = code;
        for (int i = altkey_pkg::NUM_DIGITS - 1; i >= 0; i--)
        begin
            digit[i] = 4'(rest % 10);
            rest     = rest / 10;
        end
        for (int i = 0; i < altkey_pkg::NUM_DIGITS; i++)
        begin
            if (digit[i] == 4'd0)
                usage = zero_usage_cfg;
            else
                usage = one_usage_cfg + {4'd0, digit[i]} - 8'd1;
            expected_reports.push_back('{held_modifier_cfg, usage, 1'b0});
            expected_reports.push_back('{held_modifier_cfg, 8'd0, 1'b0});
        end
        expected_reports.push_back('{8'd0, 8'd0, 1'b1});
    endfunction

    // byte parser: escape, then high and low byte taken as plain data
    function automatic void predict_reports(input logic [7:0] b);
        case (byte_phase)
            altkey_pkg::PH_HIGH:
            begin
                held_high  = b;
                byte_phase = altkey_pkg::PH_LOW;
            end
            altkey_pkg::PH_LOW:
            begin
                byte_phase = altkey_pkg::PH_CODE;
                queue_code_reports({held_high, b});
            end
            default:
            begin
                byte_phase = altkey_pkg::PH_CODE;
                if (b == altkey_pkg::ESCAPE_BYTE)
                    byte_phase = altkey_pkg::PH_HIGH;
                else
                    queue_code_reports({8'd0, b});
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        key_report_t want;
        if (!rst_n)
        begin
            expected_reports.delete();
            byte_phase        = altkey_pkg::PH_CODE;
            held_high         = 8'd0;
            held_modifier_cfg = altkey_pkg::HOLD_MODIFIER_RST;
            zero_usage_cfg    = altkey_pkg::KEYPAD_ZERO_RST;
            one_usage_cfg     = altkey_pkg::KEYPAD_ONE_RST;
            fail_tally        = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected report: modifier 0x%02h key_usage 0x%02h last %0b",
                           modifier, key_usage, last_of_run);
                    fail_tally++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (modifier !== want.modifier)
                    begin
                        $error("modifier: expected 0x%02h, got 0x%02h",
                               want.modifier, modifier);
                        fail_tally++;
                    end
                    if (key_usage !== want.key_usage)
                    begin
                        $error("key_usage: expected 0x%02h, got 0x%02h",
                               want.key_usage, key_usage);
                        fail_tally++;
                    end
                    if (last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, last_of_run);
                        fail_tally++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_reports(in_byte);
            if (cfg_we)
            begin
                case (cfg_index)
                    altkey_pkg::CFG_HOLD_MODIFIER: held_modifier_cfg = cfg_data;
                    altkey_pkg::CFG_KEYPAD_ZERO:   zero_usage_cfg    = cfg_data;
                    altkey_pkg::CFG_KEYPAD_ONE:    one_usage_cfg     = cfg_data;
                    default:                       ;
                endcase
            end
        end
        mismatches  <= fail_tally;
        reports_due <= expected_reports.size();
    end

endmodule

FILE: dv/char_code_to_alt_keypad_keys_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_code_to_alt_keypad_keys_tb
// drives byte streams of plain and escaped character codes under several
// keypad settings, with bursty input and a stalling report sink, and leaves
// prediction and comparison to the keystroke checker
// ----------------------------------------------------------------------------
module char_code_to_alt_keypad_keys_tb;

    localparam int CLK_HALF_NS     = 1;
    localparam int DRAIN_CYCLES    = 30;      // settle time after the last predicted report
    localparam int HOLD_OFF_CYCLES = 300;     // long sink hold-off, fills the block
    localparam int LIMIT_CYCLES    = 500000;  // far beyond the slowest good run

    // directed bytes with the reset settings: plain extremes, escaped
    // extremes, the escape byte taken as data, and codes using every digit
    localparam int         NUM_DIRECTED = 25;
    localparam logic [7:0] DIRECTED [NUM_DIRECTED] = '{
        8'h00, 8'h01, 8'h09, 8'h0A, 8'h7F, 8'h80, 8'hFE,
        altkey_pkg::ESCAPE_BYTE, 8'hFF, 8'hFF,  // 65535, escape bytes as data
        altkey_pkg::ESCAPE_BYTE, 8'h00, 8'h00,  // escaped zero
        altkey_pkg::ESCAPE_BYTE, 8'h00, 8'hFF,  // 255, only reachable escaped
        altkey_pkg::ESCAPE_BYTE, 8'h30, 8'h39,  // 12345
        altkey_pkg::ESCAPE_BYTE, 8'hD4, 8'h31,  // 54321
        altkey_pkg::ESCAPE_BYTE, 8'h1A, 8'h85   // 6789
    };

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte     = 8'd0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] modifier;
    logic [7:0] key_usage;
    logic       last_of_run;
    logic       cfg_we      = 1'b0;
    logic [1:0] cfg_index   = altkey_pkg::CFG_HOLD_MODIFIER;
    logic [7:0] cfg_data    = 8'd0;

    int         mismatches;
    int         reports_due;
    int         cycle_count = 0;
    int         bytes_offered = 0;
    int         burst_left  = 0;
    bit         hold_request = 1'b0;

    char_code_to_alt_keypad_keys i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .modifier    (modifier),
        .key_usage   (key_usage),
        .last_of_run (last_of_run),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    altkey_keystroke_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .modifier    (modifier),
        .key_usage   (key_usage),
        .last_of_run (last_of_run),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .reports_due (reports_due)
    );

    initial
    begin
        forever #CLK_HALF_NS clk = ~clk;
    end

    // run limit, counted on its own so a hung handshake cannot stop it
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("char_code_to_alt_keypad_keys regression: fail");
        $finish;
    end

    // report sink: stall pattern changes every so often between no stalls,
    // light stalls and heavy stalls; a hold-off request from the stimulus
    // side keeps it stalled for a long stretch counted here
    initial
    begin : report_sink
        int stall_mode;
        int stall_span;
        forever
        begin
            stall_mode = $urandom_range(0, 2);
            stall_span = $urandom_range(16, 160);
            repeat (stall_span)
            begin
                @(posedge clk);
                if (hold_request)
                begin
                    out_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    hold_request = 1'b0;
                end
                else
                begin
                    case (stall_mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    // offer one byte and return at the edge where the transaction is taken;
    // between bursts valid can drop for a random gap, sometimes a long one
    task automatic offer_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(10, 40);
            else
                gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        bytes_offered++;
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // byte biased towards the all-zeros and all-ones patterns
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one whole code: a plain byte, or escape plus high and low byte
    task automatic send_random_code();
        logic [7:0] plain;
        logic [7:0] high_byte;
        logic [7:0] low_byte;
        if ($urandom_range(0, 9) < 6)
        begin
            plain = pick_byte();
            if (plain == altkey_pkg::ESCAPE_BYTE)
                plain = 8'hFE;
            offer_byte(plain);
        end
        else
        begin
            high_byte = pick_byte();
            low_byte  = pick_byte();
            offer_byte(altkey_pkg::ESCAPE_BYTE);
            offer_byte(high_byte);
            offer_byte(low_byte);
        end
    endtask

    task automatic run_random_codes(input int num_bytes);
        int target;
        target = bytes_offered + num_bytes;
        while (bytes_offered < target)
            send_random_code();
    endtask

    // stop offering, wait for every predicted report, then let the
    // sequencer settle before anything else touches the block
    task automatic drain_reports();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // only called with the block idle
    task automatic set_keypad(input logic [7:0] hold_mod, input logic [7:0] zero_usage,
                              input logic [7:0] one_usage);
        write_register(altkey_pkg::CFG_HOLD_MODIFIER, hold_mod);
        write_register(altkey_pkg::CFG_KEYPAD_ZERO, zero_usage);
        write_register(altkey_pkg::CFG_KEYPAD_ONE, one_usage);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, directed codes
        for (int i = 0; i < NUM_DIRECTED; i++)
            offer_byte(DIRECTED[i]);
        drain_reports();

        // all registers at zero
        set_keypad(8'h00, 8'h00, 8'h00);
        run_random_codes(70);
        drain_reports();

        // all registers at full scale, usage sum wraps; sink holds off at
        // the start so the code register fills and the input stalls
        set_keypad(8'hFF, 8'hFF, 8'hFF);
        hold_request = 1'b1;
        run_random_codes(70);
        drain_reports();

        // default modifier, digit nine wraps past zero
        set_keypad(altkey_pkg::HOLD_MODIFIER_RST, 8'hFF, 8'hF8);
        run_random_codes(70);
        drain_reports();

        repeat (3)
        begin
            set_keypad(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
            run_random_codes(65);
            drain_reports();
        end

        if (mismatches == 0 && reports_due == 0)
            $display("char_code_to_alt_keypad_keys regression: pass");
        else
            $display("char_code_to_alt_keypad_keys regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/altkey_pkg.sv
rtl/char_code_to_alt_keypad_keys.sv
rtl/altkey_checker.sv
dv/altkey_keystroke_checker.sv
dv/char_code_to_alt_keypad_keys_tb.sv
